// ===== rtl/core/falt_pkg.sv =====
package falt_pkg;

  localparam int CFG_DW = 24;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] REG_MAX_FAIL = 1'd0;
  localparam logic [CFG_IW-1:0] REG_LOCKOUT  = 1'd1;

  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [7:0]  MAX_FAIL_RST = 8'd5;
  localparam logic [23:0] LOCKOUT_RST  = 24'd300;
  localparam logic [7:0]  COUNT_SAT    = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key_address;
    logic [31:0] now_seconds;
  } in_req_t;

  typedef struct packed {
    logic        locked;
    logic [23:0] retry_after;
    logic        entry_found;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  fail_count;
    logic [31:0] last_failure;
  } entry_t;

endpackage

// ===== rtl/core/falt_ram.sv =====
module falt_ram #(
  parameter int WIDTH  = 72,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/failed_attempt_lockout_table_unit.sv =====
// Failed-attempt lockout table: per-address failure records in a single-port-write RAM.
// One request at a time (in_ready only while idle); each runs a linear RAM scan
// (one entry read per cycle) for lookup, free slot and oldest stamp, then an execute
// step that issues the result once the output register is free.
// Reset (rst_n low, synchronous): all entries invalid, registers to 5 and 300, idle.
// No clearing pass: entry valid bits live in flops and clear at once.
module failed_attempt_lockout_table_unit
  import falt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output out_rsp_t          out_rsp,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES);
  localparam int EW = $bits(entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [IW:0]              cnt_r, cnt_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]            rd_idx_r, rd_idx_nxt;
  in_req_t                  req_r, req_nxt;
  logic                     found_r, found_nxt;
  logic [IW-1:0]            found_idx_r, found_idx_nxt;
  logic [7:0]               found_cnt_r, found_cnt_nxt;
  logic [31:0]              found_stamp_r, found_stamp_nxt;
  logic                     free_r, free_nxt;
  logic [IW-1:0]            free_idx_r, free_idx_nxt;
  logic                     old_r, old_nxt;
  logic [IW-1:0]            old_idx_r, old_idx_nxt;
  logic [31:0]              old_stamp_r, old_stamp_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [7:0]               max_fail_r, max_fail_nxt;
  logic [23:0]              lockout_r, lockout_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic [EW-1:0] ram_rbits;
  logic          slot_v;
  logic [31:0]   elapsed;

  falt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r[IW-1:0]),
    .rdata(ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);
  assign slot_v    = valid_r[rd_idx_r];
  assign elapsed   = req_r.now_seconds - found_stamp_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_pend_nxt     = rd_pend_r;
    rd_idx_nxt      = rd_idx_r;
    req_nxt         = req_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_cnt_nxt   = found_cnt_r;
    found_stamp_nxt = found_stamp_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    old_nxt         = old_r;
    old_idx_nxt     = old_idx_r;
    old_stamp_nxt   = old_stamp_r;
    valid_nxt       = valid_r;
    max_fail_nxt    = max_fail_r;
    lockout_nxt     = lockout_r;
    out_valid_nxt   = out_valid_r;
    out_rsp_nxt     = out_rsp_r;
    ram_we          = 1'b0;
    ram_waddr       = found_idx_r;
    ram_wdata       = '{address: req_r.key_address, fail_count: 8'd1,
                        last_failure: req_r.now_seconds};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FAIL: max_fail_nxt = cfg_wdata[7:0];
        REG_LOCKOUT:  lockout_nxt  = cfg_wdata[23:0];
        default:      ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_req;
          cnt_nxt     = '0;
          rd_pend_nxt = 1'b0;
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
          old_nxt     = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r != LAST) begin
          cnt_nxt     = cnt_r + 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_r[IW-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r) begin
          if (slot_v && !found_r && ram_rdata.address == req_r.key_address) begin
            found_nxt       = 1'b1;
            found_idx_nxt   = rd_idx_r;
            found_cnt_nxt   = ram_rdata.fail_count;
            found_stamp_nxt = ram_rdata.last_failure;
          end
          if (!slot_v && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (slot_v && (!old_r || ram_rdata.last_failure < old_stamp_r)) begin
            old_nxt       = 1'b1;
            old_idx_nxt   = rd_idx_r;
            old_stamp_nxt = ram_rdata.last_failure;
          end
        end
        if (cnt_r == LAST && !rd_pend_r) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.locked      = 1'b0;
          out_rsp_nxt.retry_after = '0;
          out_rsp_nxt.entry_found = found_r;
          unique case (req_r.op)
            OP_CHECK: begin
              if (found_r && found_cnt_r >= max_fail_r
                  && elapsed < {8'd0, lockout_r}) begin
                out_rsp_nxt.locked      = 1'b1;
                out_rsp_nxt.retry_after = lockout_r - elapsed[23:0];
              end
            end
            OP_RECORD: begin
              ram_we = 1'b1;
              if (found_r) begin
                ram_waddr            = found_idx_r;
                ram_wdata.fail_count = (found_cnt_r == COUNT_SAT) ? COUNT_SAT
                                                                  : found_cnt_r + 8'd1;
              end else if (free_r) begin
                ram_waddr = free_idx_r;
              end else begin
                ram_waddr = old_idx_r;
              end
              valid_nxt[ram_waddr] = 1'b1;
            end
            OP_CLEAR: begin
              if (found_r) begin
                valid_nxt[found_idx_r] = 1'b0;
              end
            end
            default: ;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      old_r       <= 1'b0;
      valid_r     <= '0;
      max_fail_r  <= MAX_FAIL_RST;
      lockout_r   <= LOCKOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      old_r       <= old_nxt;
      valid_r     <= valid_nxt;
      max_fail_r  <= max_fail_nxt;
      lockout_r   <= lockout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    req_r         <= req_nxt;
    found_idx_r   <= found_idx_nxt;
    found_cnt_r   <= found_cnt_nxt;
    found_stamp_r <= found_stamp_nxt;
    free_idx_r    <= free_idx_nxt;
    old_idx_r     <= old_idx_nxt;
    old_stamp_r   <= old_stamp_nxt;
    out_rsp_r     <= out_rsp_nxt;
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_locked_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.locked |-> out_rsp_r.retry_after != '0)
    else $error("locked result with zero retry time");

  a_locked_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.locked |-> out_rsp_r.entry_found)
    else $error("locked result without an entry");

  a_full_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC && !found_r && !free_r |-> old_r)
    else $error("full table without an eviction candidate");

endmodule

// ===== tb/tb_failed_attempt_lockout_table_unit.sv =====
module tb_failed_attempt_lockout_table_unit
  import falt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_N = 64;
  localparam int POOL_N = 96;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 27;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // shadow copy of the lockout table plus the queue of predicted responses
  class lockout_shadow;
    logic [7:0]  max_fail;
    logic [23:0] lockout_len;
    bit          used[TABLE_N];
    logic [31:0] owner[TABLE_N];
    logic [7:0]  fails[TABLE_N];
    logic [31:0] stamp[TABLE_N];
    out_rsp_t    verdict_q[$];
    int          failures;

    function new();
      max_fail = MAX_FAIL_RST;
      lockout_len = LOCKOUT_RST;
      foreach (used[i]) used[i] = 1'b0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == REG_MAX_FAIL) max_fail = data[7:0];
      else if (idx == REG_LOCKOUT) lockout_len = data[23:0];
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void take_request(in_req_t r);
      int s, n;
      logic [31:0] el;
      out_rsp_t v;
      s = -1;
      v = '0;
      for (int i = 0; i < TABLE_N; i++)
        if (s < 0 && used[i] && owner[i] == r.key_address) s = i;
      case (r.op)
        OP_CHECK: begin
          if (s >= 0 && fails[s] >= max_fail) begin
            el = r.now_seconds - stamp[s];
            if (el < {8'd0, lockout_len}) begin
              v.locked = 1'b1;
              v.retry_after = lockout_len - el[23:0];
            end
          end
        end
        OP_RECORD: begin
          if (s >= 0) begin
            if (fails[s] != COUNT_SAT) fails[s] = fails[s] + 8'd1;
            stamp[s] = r.now_seconds;
          end else begin
            n = -1;
            for (int i = 0; i < TABLE_N; i++)
              if (n < 0 && !used[i]) n = i;
            if (n < 0) begin
              // full: evict oldest stamp, lowest index on ties
              n = 0;
              for (int i = 1; i < TABLE_N; i++)
                if (stamp[i] < stamp[n]) n = i;
            end
            used[n] = 1'b1;
            owner[n] = r.key_address;
            fails[n] = 8'd1;
            stamp[n] = r.now_seconds;
          end
        end
        OP_CLEAR: begin
          if (s >= 0) used[s] = 1'b0;
        end
        default: ;
      endcase
      v.entry_found = (s >= 0);
      verdict_q.push_back(v);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      if (verdict_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected response: locked %0d retry %0d found %0d",
                   got.locked, got.retry_after, got.entry_found);
        return;
      end
      want = verdict_q.pop_front();
      if (got.locked !== want.locked || got.retry_after !== want.retry_after ||
          got.entry_found !== want.entry_found) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: locked exp %0d got %0d, retry exp %0d got %0d, ",
                    "found exp %0d got %0d"},
                   want.locked, got.locked, want.retry_after, got.retry_after,
                   want.entry_found, got.entry_found);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_req_t           in_req;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_rsp_t          out_rsp;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  lockout_shadow shadow;
  logic [31:0]   addr_pool[POOL_N];
  logic [31:0]   now_clk;
  bit            calm;
  int            hold_tickets;
  int            hold_seen = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  failed_attempt_lockout_table_unit #(.TABLE_ENTRIES(TABLE_N)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response side: random backpressure plus long holds on request
  always @(posedge clk) begin
    if (hold_seen != hold_tickets) begin
      hold_seen <= hold_tickets;
      stall_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) shadow.take_request(in_req);
    if (rst_n && out_valid && out_ready) shadow.check_result(out_rsp);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [31:0] addr,
                          input logic [31:0] t_now);
    in_req_t r;
    r.op = op;
    r.key_address = addr;
    r.now_seconds = t_now;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] fail_limit, input logic [23:0] hold_len);
    logic [CFG_DW-1:0] wide;
    wide = CFG_DW'($urandom);
    wide[7:0] = fail_limit;
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_FAIL;
    cfg_wdata <= wide;
    @(posedge clk);
    cfg_index <= REG_LOCKOUT;
    cfg_wdata <= hold_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    shadow.write_reg(REG_MAX_FAIL, wide);
    shadow.write_reg(REG_LOCKOUT, hold_len);
  endtask

  function automatic void advance_clock();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) now_clk = $urandom;
    else if (roll < 10) now_clk = now_clk + $urandom_range(0, 4000);
    else now_clk = now_clk + $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return addr_pool[$urandom_range(0, 3)];
    if (roll < 95) return addr_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  // probe around the lockout boundary
  function automatic logic [31:0] probe_time(input logic [31:0] base);
    logic [31:0] len;
    len = {8'd0, shadow.lockout_len};
    case ($urandom_range(0, 3))
      0: return base + len - 32'd1;
      1: return base + len;
      2: return base + $urandom_range(0, 3);
      default: return base + $urandom_range(0, 2000);
    endcase
  endfunction

  task automatic run_traffic(input int quota);
    int sent, kind, reps, roll;
    logic [31:0] a, t0;
    logic [1:0] op;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        // fill the table with equal stamps to force tie-break eviction
        t0 = now_clk;
        for (int i = 0; i < TABLE_N + 2; i++) send_req(OP_RECORD, $urandom, t0);
        sent += TABLE_N + 2;
      end else if (kind < 35) begin
        a = (kind < 8) ? pick_addr() : addr_pool[$urandom_range(0, 3)];
        reps = (kind < 8) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        for (int i = 0; i < reps; i++) begin
          advance_clock();
          send_req(OP_RECORD, a, now_clk);
        end
        t0 = now_clk;
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          send_req(OP_CHECK, a, probe_time(t0));
          sent++;
        end
        sent += reps;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) op = OP_CHECK;
        else if (roll < 80) op = OP_RECORD;
        else if (roll < 95) op = OP_CLEAR;
        else op = OP_UNUSED;
        advance_clock();
        send_req(op, pick_addr(), ($urandom_range(0, 9) == 0) ? $urandom : now_clk);
        sent++;
      end
    end
  endtask

  initial begin
    shadow = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_tickets = 0;
    now_clk = 32'd1000;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) addr_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, lockout boundaries, wrap, clear, unknown op
    send_req(OP_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) send_req(OP_RECORD, 32'h0A00_0001, 32'd100);
    send_req(OP_CHECK, 32'h0A00_0001, 32'd100);
    send_req(OP_CHECK, 32'h0A00_0001, 32'd399);
    send_req(OP_CHECK, 32'h0A00_0001, 32'd400);
    send_req(OP_CHECK, 32'h0A00_0001, 32'd99);
    send_req(OP_UNUSED, 32'h0A00_0001, 32'd100);
    send_req(OP_CLEAR, 32'h0A00_0001, 32'd100);
    send_req(OP_CLEAR, 32'h0A00_0001, 32'd100);
    send_req(OP_CHECK, 32'h0A00_0001, 32'd100);
    for (int i = 0; i < 5; i++) send_req(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_req(OP_CHECK, 32'hFFFF_FFFF, 32'h0000_000A);
    send_req(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);

    // saturate one count
    for (int i = 0; i < 260; i++) begin
      advance_clock();
      send_req(OP_RECORD, addr_pool[2], now_clk);
    end
    send_req(OP_CHECK, addr_pool[2], now_clk);
    run_traffic(220);
    drain();

    set_regs(8'd1, 24'hFF_FFFF);
    run_traffic(200);
    drain();

    set_regs(8'd255, 24'd0);
    hold_tickets++;
    run_traffic(200);
    drain();

    set_regs(8'd0, 24'd1);
    calm = 1'b1;
    run_traffic(200);
    drain();
    calm = 1'b0;

    set_regs(8'($urandom_range(1, 255)), 24'($urandom_range(1, 3000)));
    run_traffic(200);
    drain();

    set_regs(8'($urandom_range(0, 255)), 24'($urandom));
    hold_tickets++;
    run_traffic(200);
    drain();

    repeat (80) @(posedge clk);
    if (shadow.failures == 0 && shadow.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/falt_pkg.sv
rtl/core/falt_ram.sv
rtl/core/failed_attempt_lockout_table_unit.sv
tb/tb_failed_attempt_lockout_table_unit.sv
